// ===== rtl/sms_pkg.sv =====
// Package: shared types, register map and quarter-wave duty tables for the microstep sequencer
`default_nettype none
package sms_pkg;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int IN_TW  = 8;
  localparam int OUT_TW = 40;

  localparam logic [2:0] REG_STEP_TARGET    = 3'd0;
  localparam logic [2:0] REG_TICK_DIVIDER   = 3'd1;
  localparam logic [2:0] REG_MICROSTEP_MODE = 3'd2;
  localparam logic [2:0] REG_MOVE_DIRECTION = 3'd3;
  localparam logic [2:0] REG_CURRENT_LIMIT  = 3'd4;

  localparam logic [15:0] STEP_TARGET_RST   = 16'd0;
  localparam logic [7:0]  TICK_DIVIDER_RST  = 8'd1;
  localparam logic [6:0]  CURRENT_LIMIT_RST = 7'd106;

  typedef struct packed {
    logic [15:0] step_target;
    logic [7:0]  tick_divider;
    logic        microstep_mode;
    logic        move_direction;
    logic [6:0]  current_limit;
  } cfg_t;

  // Packed so that duty_a lands in the lowest bits of tdata
  typedef struct packed {
    logic        move_done;
    logic [15:0] steps_issued;
    logic [5:0]  microstep_index;
    logic        advanced;
    logic        polarity_b;
    logic        polarity_a;
    logic [6:0]  duty_b;
    logic [6:0]  duty_a;
  } res_t;

  function automatic logic [6:0] cos_q8(input logic [2:0] idx);
    logic [6:0] v;
    case (idx)
      3'd0:    v = 7'd125;
      3'd1:    v = 7'd118;
      3'd2:    v = 7'd108;
      3'd3:    v = 7'd94;
      3'd4:    v = 7'd77;
      3'd5:    v = 7'd57;
      3'd6:    v = 7'd34;
      default: v = 7'd12;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] cos_q16(input logic [3:0] idx);
    logic [6:0] v;
    case (idx)
      4'd0:    v = 7'd126;
      4'd1:    v = 7'd124;
      4'd2:    v = 7'd121;
      4'd3:    v = 7'd117;
      4'd4:    v = 7'd112;
      4'd5:    v = 7'd106;
      4'd6:    v = 7'd99;
      4'd7:    v = 7'd91;
      4'd8:    v = 7'd83;
      4'd9:    v = 7'd73;
      4'd10:   v = 7'd63;
      4'd11:   v = 7'd53;
      4'd12:   v = 7'd42;
      4'd13:   v = 7'd29;
      4'd14:   v = 7'd18;
      default: v = 7'd6;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sms_cfg_regs.sv =====
// Configuration register bank behind the APB-style port
`default_nettype none
module sms_cfg_regs
  import sms_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_target    <= STEP_TARGET_RST;
      cfg_r.tick_divider   <= TICK_DIVIDER_RST;
      cfg_r.microstep_mode <= 1'b0;
      cfg_r.move_direction <= 1'b0;
      cfg_r.current_limit  <= CURRENT_LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_STEP_TARGET:    cfg_r.step_target    <= pwdata[15:0];
        REG_TICK_DIVIDER:   cfg_r.tick_divider   <= pwdata[7:0];
        REG_MICROSTEP_MODE: cfg_r.microstep_mode <= pwdata[0];
        REG_MOVE_DIRECTION: cfg_r.move_direction <= pwdata[0];
        REG_CURRENT_LIMIT:  cfg_r.current_limit  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_STEP_TARGET:    prdata = {16'd0, cfg_r.step_target};
      REG_TICK_DIVIDER:   prdata = {24'd0, cfg_r.tick_divider};
      REG_MICROSTEP_MODE: prdata = {31'd0, cfg_r.microstep_mode};
      REG_MOVE_DIRECTION: prdata = {31'd0, cfg_r.move_direction};
      REG_CURRENT_LIMIT:  prdata = {25'd0, cfg_r.current_limit};
      default:            prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/sms_core.sv =====
// Sequencer state: tick divider, step pointer, table lookup, clamp and held duties
`default_nettype none
module sms_core
  import sms_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire cfg_t cfg,
  input  wire logic step_en,
  input  wire logic tick,
  output res_t      res
);

  logic [7:0]  tick_counter_r, tick_counter_nxt;
  logic [5:0]  step_pointer_r, step_pointer_nxt;
  logic [15:0] steps_done_r, steps_done_nxt;
  logic [6:0]  held_duty_a_r, held_duty_a_nxt;
  logic [6:0]  held_duty_b_r, held_duty_b_nxt;
  logic [5:0]  held_index_r, held_index_nxt;

  logic [7:0] cnt_inc;
  logic       run, hit;
  logic [5:0] p, p_mv;
  logic [1:0] q, hq;
  logic [3:0] j, jr, qmask, ja, jb;
  logic [6:0] c, s;

  assign cnt_inc = tick_counter_r + 8'd1;
  assign run     = tick && (steps_done_r < cfg.step_target);
  assign hit     = run && (cnt_inc == cfg.tick_divider);

  assign p     = cfg.microstep_mode ? step_pointer_r : {1'b0, step_pointer_r[4:0]};
  assign q     = cfg.microstep_mode ? p[5:4] : p[4:3];
  assign qmask = cfg.microstep_mode ? 4'hF : 4'h7;
  assign j     = cfg.microstep_mode ? p[3:0] : {1'b0, p[2:0]};
  assign jr    = qmask - j;
  assign ja    = q[0] ? jr : j;
  assign jb    = q[0] ? j : jr;
  assign c     = cfg.microstep_mode ? cos_q16(ja) : cos_q8(ja[2:0]);
  assign s     = cfg.microstep_mode ? cos_q16(jb) : cos_q8(jb[2:0]);
  assign p_mv  = cfg.move_direction ? p - 6'd1 : p + 6'd1;

  always_comb begin
    tick_counter_nxt = tick_counter_r;
    step_pointer_nxt = step_pointer_r;
    steps_done_nxt   = steps_done_r;
    held_duty_a_nxt  = held_duty_a_r;
    held_duty_b_nxt  = held_duty_b_r;
    held_index_nxt   = held_index_r;
    if (run) begin
      tick_counter_nxt = cnt_inc;
    end
    if (hit) begin
      tick_counter_nxt = '0;
      steps_done_nxt   = steps_done_r + 16'd1;
      held_duty_a_nxt  = (c > cfg.current_limit) ? cfg.current_limit : c;
      held_duty_b_nxt  = (s > cfg.current_limit) ? cfg.current_limit : s;
      held_index_nxt   = p;
      step_pointer_nxt = cfg.microstep_mode ? p_mv : {1'b0, p_mv[4:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_counter_r <= '0;
      step_pointer_r <= '0;
      steps_done_r   <= '0;
      held_duty_a_r  <= '0;
      held_duty_b_r  <= '0;
      held_index_r   <= '0;
    end else if (step_en) begin
      tick_counter_r <= tick_counter_nxt;
      step_pointer_r <= step_pointer_nxt;
      steps_done_r   <= steps_done_nxt;
      held_duty_a_r  <= held_duty_a_nxt;
      held_duty_b_r  <= held_duty_b_nxt;
      held_index_r   <= held_index_nxt;
    end
  end

  assign hq = cfg.microstep_mode ? held_index_nxt[5:4] : held_index_nxt[4:3];

  always_comb begin
    res.duty_a          = held_duty_a_nxt;
    res.duty_b          = held_duty_b_nxt;
    res.polarity_a      = hq[0] ^ hq[1];
    res.polarity_b      = hq[1];
    res.advanced        = hit;
    res.microstep_index = held_index_nxt;
    res.steps_issued    = steps_done_nxt;
    res.move_done       = steps_done_nxt >= cfg.step_target;
  end

endmodule
`default_nettype wire

// ===== rtl/stepper_microstep_sequencer_top.sv =====
// Top level: stream channels, input and result registers, configuration port
//
// Sine microstep sequencer for a two-winding stepper. Each input transfer is one
// timer poll; each produces exactly one result transfer carrying the held winding
// duties, bridge polarities, table index, step count and a done flag. One transfer
// is taken every clock while out_tready stays high: the input register feeds a single
// pass of compare, increment, table lookup and clamp into the result register, so
// throughput is one item per cycle. Write the configuration registers only while no
// transfer is in flight.
`default_nettype none
module stepper_microstep_sequencer_top
  import sms_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_TW-1:0]  in_tdata,   // [0] tick_present
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // [6:0] duty_a, [13:7] duty_b, [14] polarity_a, [15] polarity_b, [16] advanced,
  // [22:17] microstep_index, [38:23] steps_issued, [39] move_done
  output logic      [OUT_TW-1:0] out_tdata,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t cfg;
  res_t res;
  res_t out_r;
  logic in_valid_r;
  logic in_tick_r;
  logic out_valid_r;
  logic proc_en;

  sms_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign proc_en   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_tick_r <= in_tdata[0];
    end
  end

  sms_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step_en (proc_en),
    .tick    (in_tick_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.advanced && !cfg.microstep_mode) |-> !out_r.microstep_index[5])
    else $error("microstep index beyond 32-entry cycle");

  a_duty_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.advanced) |->
      (out_r.duty_a <= cfg.current_limit && out_r.duty_b <= cfg.current_limit))
    else $error("duty above current limit on a new microstep");

  a_no_tick_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_en && !in_tick_r) |=> !out_r.advanced)
    else $error("microstep issued without a tick");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/stepper_microstep_sequencer_checker.sv =====
// Checker for the microstep sequencer: mirrors registers, predicts each result and compares
`timescale 1ns / 100ps
module stepper_microstep_sequencer_checker
  import sms_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_TW-1:0]  in_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_TW-1:0] out_tdata,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic              cfg_pready,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output int                outstanding,
  output int                errors,
  output int                n_results,
  output int                n_steps
);

  // quarter-wave cosine, entry 0 in the lowest bits
  localparam logic [8*7-1:0] WAVE8 = {7'd12, 7'd34, 7'd57, 7'd77, 7'd94, 7'd108, 7'd118,
                                      7'd125};
  localparam logic [16*7-1:0] WAVE16 = {7'd6, 7'd18, 7'd29, 7'd42, 7'd53, 7'd63, 7'd73,
                                        7'd83, 7'd91, 7'd99, 7'd106, 7'd112, 7'd117,
                                        7'd121, 7'd124, 7'd126};

  cfg_t        regs;
  logic [7:0]  tick_cnt;
  logic [5:0]  ptr;
  logic [15:0] steps;
  logic [6:0]  hold_a;
  logic [6:0]  hold_b;
  logic [5:0]  hold_idx;
  res_t        predicted_reports[$];
  res_t        want;
  res_t        got;

  initial begin
    errors = 0;
    n_results = 0;
    n_steps = 0;
    outstanding = 0;
  end

  function automatic res_t advance_sequencer(input logic tick);
    res_t       r;
    logic [5:0] p;
    logic [1:0] q;
    logic [1:0] hq;
    logic [3:0] j;
    logic [3:0] jr;
    logic [3:0] tmp;
    logic [6:0] c;
    logic [6:0] s;
    logic       adv;
    adv = 1'b0;
    if (tick && steps < regs.step_target) begin
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt == regs.tick_divider) begin
        tick_cnt = 8'd0;
        p = regs.microstep_mode ? ptr : {1'b0, ptr[4:0]};
        q = regs.microstep_mode ? p[5:4] : p[4:3];
        j = regs.microstep_mode ? p[3:0] : {1'b0, p[2:0]};
        jr = (regs.microstep_mode ? 4'd15 : 4'd7) - j;
        if (q[0]) begin
          tmp = j;
          j = jr;
          jr = tmp;
        end
        c = regs.microstep_mode ? WAVE16[j*7 +: 7] : WAVE8[j[2:0]*7 +: 7];
        s = regs.microstep_mode ? WAVE16[jr*7 +: 7] : WAVE8[jr[2:0]*7 +: 7];
        hold_a = (c > regs.current_limit) ? regs.current_limit : c;
        hold_b = (s > regs.current_limit) ? regs.current_limit : s;
        hold_idx = p;
        if (regs.microstep_mode)
          ptr = regs.move_direction ? p - 6'd1 : p + 6'd1;
        else
          ptr = {1'b0, (regs.move_direction ? p[4:0] - 5'd1 : p[4:0] + 5'd1)};
        steps = steps + 16'd1;
        adv = 1'b1;
      end
    end
    hq = regs.microstep_mode ? hold_idx[5:4] : hold_idx[4:3];
    r.duty_a = hold_a;
    r.duty_b = hold_b;
    r.polarity_a = (hq == 2'd1 || hq == 2'd2);
    r.polarity_b = hq[1];
    r.advanced = adv;
    r.microstep_index = hold_idx;
    r.steps_issued = steps;
    r.move_done = (steps >= regs.step_target);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      regs.step_target = STEP_TARGET_RST;
      regs.tick_divider = TICK_DIVIDER_RST;
      regs.microstep_mode = 1'b0;
      regs.move_direction = 1'b0;
      regs.current_limit = CURRENT_LIMIT_RST;
      tick_cnt = 8'd0;
      ptr = 6'd0;
      steps = 16'd0;
      hold_a = 7'd0;
      hold_b = 7'd0;
      hold_idx = 6'd0;
      predicted_reports.delete();
      outstanding <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_AW-1:2])
          REG_STEP_TARGET:    regs.step_target = cfg_pwdata[15:0];
          REG_TICK_DIVIDER:   regs.tick_divider = cfg_pwdata[7:0];
          REG_MICROSTEP_MODE: regs.microstep_mode = cfg_pwdata[0];
          REG_MOVE_DIRECTION: regs.move_direction = cfg_pwdata[0];
          REG_CURRENT_LIMIT:  regs.current_limit = cfg_pwdata[6:0];
          default: ;
        endcase
      end
      // result side first: a result never belongs to a poll taken at the same edge
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (predicted_reports.size() == 0) begin
          $error("result transfer with nothing expected: %h", out_tdata);
          errors++;
        end else begin
          want = predicted_reports.pop_front();
          n_results++;
          if (want.advanced) n_steps++;
          check_field("duty_a", want.duty_a, got.duty_a);
          check_field("duty_b", want.duty_b, got.duty_b);
          check_field("polarity_a", want.polarity_a, got.polarity_a);
          check_field("polarity_b", want.polarity_b, got.polarity_b);
          check_field("advanced", want.advanced, got.advanced);
          check_field("microstep_index", want.microstep_index, got.microstep_index);
          check_field("steps_issued", want.steps_issued, got.steps_issued);
          check_field("move_done", want.move_done, got.move_done);
        end
      end
      if (in_tvalid && in_tready)
        predicted_reports.push_back(advance_sequencer(in_tdata[0]));
      outstanding <= predicted_reports.size();
    end
  end

endmodule

// ===== tb/sv/stepper_microstep_sequencer_top_tb.sv =====
// Testbench top: clock, reset, register programming, poll stimulus and verdict
`timescale 1ns / 100ps
module stepper_microstep_sequencer_top_tb;
  import sms_pkg::*;

  localparam int QUIET_LIMIT = 1000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_TW-1:0]  in_tdata;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_TW-1:0] out_tdata;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  int outstanding;
  int errors;
  int n_results;
  int n_steps;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet;
  int n_settings;

  stepper_microstep_sequencer_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  stepper_microstep_sequencer_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .outstanding (outstanding),
    .errors      (errors),
    .n_results   (n_results),
    .n_steps     (n_steps)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // watchdog on cycles without any transfer
  initial quiet = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("stepper_microstep_sequencer_top_tb: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_motion(input logic [15:0] target, input logic [7:0] divider,
                                input logic mode, input logic dir, input logic [6:0] limit);
    wait_drained();
    apb_write(REG_STEP_TARGET, {16'd0, target});
    apb_write(REG_TICK_DIVIDER, {24'd0, divider});
    apb_write(REG_MICROSTEP_MODE, {31'd0, mode});
    apb_write(REG_MOVE_DIRECTION, {31'd0, dir});
    apb_write(REG_CURRENT_LIMIT, {25'd0, limit});
    n_settings++;
  endtask

  task automatic push_poll(input logic tick);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_TW-1){1'b0}}, tick};
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    logic [15:0] target;
    logic [7:0]  divider;
    logic [6:0]  limit;
    int          sel;
    int          n_polls;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_settings = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: target zero, so nothing moves, zero duties are reported and move_done is set
    push_poll(1'b1);
    push_poll(1'b0);
    // 16 per quadrant, backward from zero through the wrap, duties clamped to zero
    program_motion(16'hFFFF, 8'd1, 1'b1, 1'b1, 7'd0);
    repeat (6) push_poll(1'b1);
    // back to 8 per quadrant with the pointer past the short table, no clamp
    program_motion(16'hFFFF, 8'd1, 1'b0, 1'b0, 7'd127);
    push_poll(1'b0);
    repeat (4) push_poll(1'b1);
    // slower divider with a poll without tick in the middle, mid-range clamp
    program_motion(16'hFFFF, 8'd3, 1'b1, 1'b0, 7'd90);
    repeat (4) push_poll(1'b1);
    push_poll(1'b0);
    repeat (3) push_poll(1'b1);
    // target lowered below the count already issued
    program_motion(16'd5, 8'd3, 1'b1, 1'b0, 7'd90);
    repeat (2) push_poll(1'b1);

    for (int ph = 0; ph < 14; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      sel = $urandom_range(5);
      divider = (sel == 0) ? 8'd1 : (sel == 1) ? 8'd255 : 8'($urandom_range(1, 4));
      sel = $urandom_range(7);
      target = (sel == 0) ? 16'd0 : (sel <= 2) ? 16'($urandom_range(0, 1200)) : 16'hFFFF;
      sel = $urandom_range(3);
      limit = (sel == 0) ? 7'd0 : (sel == 1) ? 7'd127 : 7'($urandom_range(0, 127));
      // divider zero: the tick counter wraps, one microstep per 256 ticks
      if (ph == 6) begin
        divider = 8'd0;
        target = 16'hFFFF;
      end
      program_motion(target, divider, 1'($urandom_range(1)), 1'($urandom_range(1)), limit);
      n_polls = (divider == 8'd0) ? 300 : 60;
      repeat (n_polls) push_poll($urandom_range(99) < 85);
    end

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Run covered %0d polls with %0d microsteps issued across %0d register settings,",
             n_results, n_steps, n_settings);
    $display("both step modes and directions, clamp limits 0 to 127 and dividers 0, 1 and 255.");
    if (errors == 0)
      $display("stepper_microstep_sequencer_top_tb: clean");
    else
      $display("stepper_microstep_sequencer_top_tb: errors");
    $finish;
  end

endmodule
